### rtl/core/kthl_pkg.sv
// kthl_pkg: shared types and constants of the k-th largest min-heap core
// no dependencies

package kthl_pkg;

    localparam int CFG_WIDTH = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_ROOT,
        ST_RT_CMP,
        ST_DN_CMP,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic fire;
        logic short_flag;
    } emit_ctl_t;

endpackage

### rtl/core/kthl_heap_ram.sv
// kthl_heap_ram: heap entry store, one write port and two registered read ports
// depends on kthl_pkg

module kthl_heap_ram
    import kthl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 6
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_WIDTH-1:0]        wr_addr,
    input  logic signed [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_WIDTH-1:0]        rd_addr_a,
    input  logic [ADDR_WIDTH-1:0]        rd_addr_b,
    output logic signed [DATA_WIDTH-1:0] rd_data_a,
    output logic signed [DATA_WIDTH-1:0] rd_data_b
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/core/kthl_ctrl.sv
// kthl_ctrl: sequencer for sift-up insert, root replace with sift-down, and result
// depends on kthl_pkg; drives the ports of kthl_heap_ram

module kthl_ctrl
    import kthl_pkg::*;
#(
    parameter int K_MAX = 64,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 6,
    parameter int CNT_WIDTH = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    input  logic [CFG_WIDTH-1:0]         heap_size,
    input  logic                         out_free,
    output emit_ctl_t                    emit,
    output logic signed [DATA_WIDTH-1:0] emit_value,
    output logic                         wr_en,
    output logic [ADDR_WIDTH-1:0]        wr_addr,
    output logic signed [DATA_WIDTH-1:0] wr_data,
    output logic [ADDR_WIDTH-1:0]        rd_addr_a,
    output logic [ADDR_WIDTH-1:0]        rd_addr_b,
    input  logic signed [DATA_WIDTH-1:0] rd_data_a,
    input  logic signed [DATA_WIDTH-1:0] rd_data_b
);

    localparam int XW = ADDR_WIDTH + 2;
    localparam int CMPW = (CNT_WIDTH > CFG_WIDTH) ? CNT_WIDTH : CFG_WIDTH;
    localparam logic [CMPW-1:0] KMAX_C = CMPW'(K_MAX);
    localparam logic [CNT_WIDTH-1:0] KMAX_N = CNT_WIDTH'(K_MAX);

    ctrl_state_t state_reg, state_next;
    logic [CNT_WIDTH-1:0] fill_reg, fill_next;
    logic [CNT_WIDTH-1:0] k_reg, k_next;
    logic [ADDR_WIDTH-1:0] idx_reg, idx_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic last_reg, last_next;

    logic [CMPW-1:0] hs_ext;
    logic [CNT_WIDTH-1:0] k_now;
    logic [CNT_WIDTH-1:0] fill_m1;
    logic [ADDR_WIDTH-1:0] par_idx;
    logic [XW-1:0] left_idx, right_idx, n_ext;
    logic signed [DATA_WIDTH-1:0] child_val;
    logic [ADDR_WIDTH-1:0] child_idx;
    logic left_ok, right_ok, take_right;
    logic [XW-1:0] sel_ext;
    logic [XW-1:0] cl_next, cr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        idx_reg  <= idx_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        hs_ext = CMPW'(heap_size);
        if (hs_ext == '0)
        begin
            k_now = CNT_WIDTH'(1);
        end
        else if (hs_ext > KMAX_C)
        begin
            k_now = KMAX_N;
        end
        else
        begin
            k_now = CNT_WIDTH'(hs_ext);
        end

        fill_m1   = fill_reg - CNT_WIDTH'(1);
        par_idx   = (idx_reg - ADDR_WIDTH'(1)) >> 1;
        left_idx  = XW'({idx_reg, 1'b1});
        right_idx = left_idx + XW'(1);
        n_ext     = XW'(fill_reg);
        left_ok   = left_idx < n_ext;
        right_ok  = right_idx < n_ext;
        take_right = right_ok && (rd_data_b < rd_data_a);
        child_val = take_right ? rd_data_b : rd_data_a;
        child_idx = take_right ? right_idx[ADDR_WIDTH-1:0] : left_idx[ADDR_WIDTH-1:0];
        sel_ext   = XW'(child_idx);
        cl_next   = XW'({child_idx, 1'b1});
        cr_next   = cl_next + XW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        in_stall   = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = key_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        emit       = '0;
        emit_value = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    key_next  = value;
                    last_next = last;
                    k_next    = k_now;
                    if ((fill_reg < k_now) && (fill_reg < KMAX_N))
                    begin
                        fill_next = fill_reg + CNT_WIDTH'(1);
                        idx_next  = ADDR_WIDTH'(fill_reg);
                        if (fill_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = value;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            rd_addr_a  = ADDR_WIDTH'(fill_m1 >> 1);
                            state_next = ST_UP_CMP;
                        end
                    end
                    else if (fill_reg != '0)
                    begin
                        rd_addr_a  = '0;
                        state_next = ST_RT_CMP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_UP_CMP:
            begin
                if (key_reg < rd_data_a)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = idx_reg;
                    wr_data   = rd_data_a;
                    idx_next  = par_idx;
                    rd_addr_a = (par_idx - ADDR_WIDTH'(1)) >> 1;
                    if (par_idx == '0)
                    begin
                        state_next = ST_UP_ROOT;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_UP_ROOT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                state_next = ST_FINISH;
            end

            ST_RT_CMP:
            begin
                if (key_reg > rd_data_a)
                begin
                    idx_next   = '0;
                    rd_addr_a  = ADDR_WIDTH'(1);
                    rd_addr_b  = ADDR_WIDTH'(2);
                    state_next = ST_DN_CMP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (left_ok && (child_val < key_reg))
                begin
                    wr_data   = child_val;
                    idx_next  = child_idx;
                    rd_addr_a = cl_next[ADDR_WIDTH-1:0];
                    rd_addr_b = cr_next[ADDR_WIDTH-1:0];
                    if (sel_ext >= n_ext)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                rd_addr_a  = '0;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.fire = 1'b1;
                    if ((fill_reg < k_reg) || (fill_reg == '0))
                    begin
                        emit.short_flag = 1'b1;
                        emit_value      = '0;
                    end
                    else
                    begin
                        emit_value = rd_data_a;
                    end
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/kth_largest_min_heap_core.sv
// kth_largest_min_heap_core: streaming k-th largest selector over a min-heap memory
// requests: one at a time; in_stall is held while the sift walks the heap memory read ports one
// level per cycle, and on last while the result waits for a free output register
// reset: rst_n async clears fill count, state, output valid; heap_size resets to 1
// depends on kthl_pkg, kthl_ctrl, kthl_heap_ram

module kth_largest_min_heap_core
    import kthl_pkg::*;
#(
    parameter int K_MAX = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] kth_value,
    output logic                         short_stream,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_WIDTH-1:0]         cfg_data
);

    localparam int ADDR_WIDTH = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_WIDTH = $clog2(K_MAX + 1);

    logic [CFG_WIDTH-1:0] heap_size_reg;
    logic out_valid_reg;
    logic signed [DATA_WIDTH-1:0] kth_value_reg;
    logic short_stream_reg;

    emit_ctl_t emit;
    logic signed [DATA_WIDTH-1:0] emit_value;
    logic out_free;

    logic wr_en;
    logic [ADDR_WIDTH-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic signed [DATA_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign kth_value    = kth_value_reg;
    assign short_stream = short_stream_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= CFG_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                heap_size_reg <= cfg_data;
            end
            if (emit.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.fire)
        begin
            kth_value_reg    <= emit_value;
            short_stream_reg <= emit.short_flag;
        end
    end

    kthl_ctrl #(
        .K_MAX(K_MAX),
        .DATA_WIDTH(DATA_WIDTH),
        .ADDR_WIDTH(ADDR_WIDTH),
        .CNT_WIDTH(CNT_WIDTH)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .last(last),
        .heap_size(heap_size_reg),
        .out_free(out_free),
        .emit(emit),
        .emit_value(emit_value),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_data_a),
        .rd_data_b(rd_data_b)
    );

    kthl_heap_ram #(
        .DEPTH(K_MAX),
        .DATA_WIDTH(DATA_WIDTH),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_data_a),
        .rd_data_b(rd_data_b)
    );

endmodule

### tb/kth_rank_checker.sv
// kth_rank_checker: watches the request, result and register channels of the k-th largest core
// keeps its own min-heap of the stream and compares every result with the predicted one
// depends on kthl_pkg

module kth_rank_checker
    import kthl_pkg::*;
#(
    parameter int K_MAX = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [DATA_WIDTH-1:0] kth_value,
    input  logic                         short_stream,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_WIDTH-1:0]         cfg_data,
    output int                           fail_count,
    output int                           backlog
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] kth;
        logic                         short_flag;
    } rank_result_t;

    rank_result_t                 rank_results_q[$];
    logic signed [DATA_WIDTH-1:0] heap_vals [K_MAX];
    int                           held;
    logic [CFG_WIDTH-1:0]         rank_reg;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic swap_vals(input int a, input int b);
        logic signed [DATA_WIDTH-1:0] t;
        t = heap_vals[a];
        heap_vals[a] = heap_vals[b];
        heap_vals[b] = t;
    endtask

    task automatic absorb(input logic signed [DATA_WIDTH-1:0] v, input logic fin);
        int k;
        int i;
        int p;
        int l;
        int r;
        int s;
        bit moving;
        rank_result_t res;
        k = int'(rank_reg);
        if (k == 0)
            k = 1;
        if (k > K_MAX)
            k = K_MAX;
        if (held < k && held < K_MAX)
        begin
            heap_vals[held] = v;
            i = held;
            moving = 1'b1;
            while (moving && i > 0)
            begin
                p = (i - 1) / 2;
                if (heap_vals[i] < heap_vals[p])
                begin
                    swap_vals(i, p);
                    i = p;
                end
                else
                    moving = 1'b0;
            end
            held++;
        end
        else if (held > 0 && v > heap_vals[0])
        begin
            // replace the root, ties stay with the left child
            heap_vals[0] = v;
            i = 0;
            moving = 1'b1;
            while (moving)
            begin
                s = i;
                l = 2 * i + 1;
                r = 2 * i + 2;
                if (l < held && heap_vals[l] < heap_vals[s])
                    s = l;
                if (r < held && heap_vals[r] < heap_vals[s])
                    s = r;
                if (s == i)
                    moving = 1'b0;
                else
                begin
                    swap_vals(i, s);
                    i = s;
                end
            end
        end
        if (fin)
        begin
            if (held < k || held == 0)
            begin
                res.kth = '0;
                res.short_flag = 1'b1;
            end
            else
            begin
                res.kth = heap_vals[0];
                res.short_flag = 1'b0;
            end
            rank_results_q.push_back(res);
            held = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rank_result_t want;
        if (!rst_n)
        begin
            held = 0;
            rank_reg = CFG_WIDTH'(1);
            rank_results_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (rank_results_q.size() == 0)
                    report($sformatf("unexpected result kth_value %0d short %0b",
                                     kth_value, short_stream));
                else
                begin
                    want = rank_results_q.pop_front();
                    if (kth_value !== want.kth)
                        report($sformatf("kth_value %0d, predicted %0d", kth_value, want.kth));
                    if (short_stream !== want.short_flag)
                        report($sformatf("short_stream %0b, predicted %0b",
                                         short_stream, want.short_flag));
                end
            end
            if (in_valid && !in_stall)
                absorb(value, last);
            if (cfg_valid && cfg_ready)
                rank_reg = cfg_data;
        end
        backlog <= rank_results_q.size();
    end

endmodule

### tb/testbench.sv
// testbench: stimulus and verdict for kth_largest_min_heap_core
// directed streams, then random streams over many rank settings with random idling
// depends on kthl_pkg, kth_largest_min_heap_core, kth_rank_checker

module testbench;
    import kthl_pkg::*;

    localparam int K_MAX = 64;
    localparam int DW = 32;
    localparam int SETTLE = 16;
    localparam int ITEM_TARGET = 1700;
    localparam int QUIET_AFTER = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [DW-1:0] value = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] kth_value;
    logic                 short_stream;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    int fail_count;
    int backlog;
    int sent = 0;
    int stall_left = 0;
    bit gap_on = 1'b1;
    bit stall_on = 1'b1;
    int cur_rank = 1;

    kth_largest_min_heap_core #(.K_MAX(K_MAX), .DATA_WIDTH(DW)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kth_value(kth_value),
        .short_stream(short_stream),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    kth_rank_checker #(.K_MAX(K_MAX), .DATA_WIDTH(DW)) rank_chk (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kth_value(kth_value),
        .short_stream(short_stream),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .backlog(backlog)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left == 0 && stall_on && sent < QUIET_AFTER && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push(input logic signed [DW-1:0] v, input logic fin);
        in_valid <= 1'b1;
        value <= v;
        last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        if (gap_on && sent < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // hold requests until every result is out and the core has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_rank(input logic [CFG_WIDTH-1:0] k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_rank = (k == 0) ? 1 : ((int'(k) > K_MAX) ? K_MAX : int'(k));
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DW-1){1'b0}}};
            1: return {1'b0, {(DW-1){1'b1}}};
            2, 3: return DW'($urandom_range(0, 8) - 4);
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_rank();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CFG_WIDTH'($urandom_range(K_MAX + 1, 127));
            2: return CFG_WIDTH'(K_MAX);
            3: return CFG_WIDTH'($urandom_range(9, K_MAX - 1));
            default: return CFG_WIDTH'($urandom_range(1, 8));
        endcase
    endfunction

    initial
    begin
        int len;
        int streams;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rank of one, most negative value
        push({1'b1, {(DW-1){1'b0}}}, 1'b1);
        // rank zero acts as one
        set_rank('0);
        push({1'b0, {(DW-1){1'b1}}}, 1'b1);
        // short stream
        set_rank(CFG_WIDTH'(3));
        push(-7, 1'b0);
        push(12, 1'b1);
        // ties among equal values
        push(5, 1'b0);
        push(5, 1'b0);
        push(5, 1'b0);
        push(7, 1'b0);
        push(5, 1'b1);
        // rank above the heap depth, short
        set_rank(CFG_WIDTH'(127));
        push(1, 1'b0);
        push(-1, 1'b0);
        push(0, 1'b1);
        // rank changed mid-stream, up then down
        set_rank(CFG_WIDTH'(2));
        push(3, 1'b0);
        push(9, 1'b0);
        set_rank(CFG_WIDTH'(4));
        push(1, 1'b0);
        set_rank(CFG_WIDTH'(1));
        push(10, 1'b1);
        // one-item streams: at rank one, then short at rank K_MAX
        push(-2, 1'b1);
        set_rank(CFG_WIDTH'(K_MAX));
        push(4, 1'b1);
        set_rank(CFG_WIDTH'(1));

        while (sent < ITEM_TARGET)
        begin
            set_rank(pick_rank());
            gap_on = (sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            stall_on = (sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            streams = (cur_rank > 16) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            repeat (streams)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, cur_rank);
                else
                    len = cur_rank + $urandom_range(0, (cur_rank < 8) ? 12 : cur_rank / 2);
                for (int n = 1; n <= len; n++)
                begin
                    if (n < len && $urandom_range(0, 59) == 0)
                        set_rank(pick_rank());
                    push(pick_value(), n == len);
                end
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
